[hw/rtl/circuit_breaker_table_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the circuit breaker table
// Shared immediate-implication and next-cycle checks, clocked on clk and
// disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef CIRCUIT_BREAKER_TABLE_TOP_ASSERT_SVH
`define CIRCUIT_BREAKER_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define CBT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cbt check failed in same cycle");

// next-cycle implication
`define CBT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cbt check failed in next cycle");

`endif

[hw/rtl/cbt_pkg.sv]
// ---------------------------------------------------------------------------
// cbt_pkg
// Types and constants shared by the circuit breaker table modules.
// ---------------------------------------------------------------------------
package cbt_pkg;

	typedef enum logic [1:0] {
		CMD_QUERY = 2'd0,
		CMD_FAIL  = 2'd1,
		CMD_PASS  = 2'd2
	} cbt_cmd_t;

	localparam logic [3:0] CFG_IDX_ENABLE    = 4'd0;
	localparam logic [3:0] CFG_IDX_THRESHOLD = 4'd1;
	localparam logic [3:0] CFG_IDX_COOLDOWN  = 4'd2;
	localparam logic [3:0] CFG_IDX_COUNT     = 4'd3;

	localparam logic [15:0] CNT_MAX  = 16'hFFFF;
	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

	// one table entry, 50 bits
	typedef struct packed {
		logic        open_mark;
		logic        probe_taken;
		logic [31:0] open_until;
		logic [15:0] failure_count;
	} cbt_entry_t;

	typedef struct packed {
		logic        breaker_enable;
		logic [15:0] failure_threshold;
		logic [15:0] cooldown_seconds;
		logic [6:0]  backend_count;
	} cbt_cfg_t;

	typedef struct packed {
		logic tripped;
		logic probe_granted;
		logic blocked;
	} cbt_result_t;

endpackage

[hw/rtl/cbt_cfg.sv]
// ---------------------------------------------------------------------------
// cbt_cfg
// Configuration register file; writes beyond the register list are dropped.
// ---------------------------------------------------------------------------
module cbt_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [3:0]         wr_index,
	input  logic [15:0]        wr_data,
	output cbt_pkg::cbt_cfg_t  cfg
);
	import cbt_pkg::*;

	cbt_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.breaker_enable    <= 1'b0;
			cfg_q.failure_threshold <= 16'd5;
			cfg_q.cooldown_seconds  <= 16'd30;
			cfg_q.backend_count     <= 7'd0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_IDX_ENABLE:    cfg_q.breaker_enable    <= wr_data[0];
				CFG_IDX_THRESHOLD: cfg_q.failure_threshold <= wr_data;
				CFG_IDX_COOLDOWN:  cfg_q.cooldown_seconds  <= wr_data;
				CFG_IDX_COUNT:     cfg_q.backend_count     <= wr_data[6:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/cbt_mem.sv]
// ---------------------------------------------------------------------------
// cbt_mem
// Breaker table storage: one write port, one enabled read port, read-first.
// ---------------------------------------------------------------------------
module cbt_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  cbt_pkg::cbt_entry_t    wdata,
	input  logic                   re,
	input  logic [AW-1:0]          raddr,
	output cbt_pkg::cbt_entry_t    rdata
);
	import cbt_pkg::*;

	cbt_entry_t mem [DEPTH];
	cbt_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// holds its value until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/cbt_update.sv]
// ---------------------------------------------------------------------------
// cbt_update
// Breaker update: new entry, write enable and result for one command.
// ---------------------------------------------------------------------------
module cbt_update (
	input  cbt_pkg::cbt_cfg_t    cfg,
	input  cbt_pkg::cbt_cmd_t    cmd,
	input  logic                 in_range,
	input  logic [31:0]          now_seconds,
	input  cbt_pkg::cbt_entry_t  cur,
	output cbt_pkg::cbt_entry_t  nxt,
	output logic                 we,
	output cbt_pkg::cbt_result_t res
);
	import cbt_pkg::*;

	logic [15:0] cnt_inc;
	logic [32:0] until_sum;
	logic [31:0] until_sat;

	assign cnt_inc   = (cur.failure_count == CNT_MAX) ? CNT_MAX : cur.failure_count + 16'd1;
	assign until_sum = {1'b0, now_seconds} + {17'd0, cfg.cooldown_seconds};
	assign until_sat = until_sum[32] ? TIME_MAX : until_sum[31:0];

	always_comb begin
		nxt = cur;
		we  = 1'b0;
		res = '0;
		if (in_range) begin
			case (cmd)
				CMD_QUERY: begin
					we = 1'b1;
					if (cfg.breaker_enable && cur.open_mark) begin
						if ((now_seconds >= cur.open_until) && !cur.probe_taken) begin
							nxt.probe_taken   = 1'b1;
							res.probe_granted = 1'b1;
						end else begin
							res.blocked = 1'b1;
						end
					end
				end
				CMD_FAIL: begin
					we                = 1'b1;
					nxt.probe_taken   = 1'b0;
					nxt.failure_count = cnt_inc;
					if (cfg.breaker_enable && (cnt_inc >= cfg.failure_threshold)) begin
						nxt.open_until = until_sat;
						nxt.open_mark  = 1'b1;
						res.tripped    = 1'b1;
					end
				end
				CMD_PASS: begin
					we  = 1'b1;
					nxt = '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[hw/rtl/circuit_breaker_table_top.sv]
// ---------------------------------------------------------------------------
// circuit_breaker_table_top
// Per-backend circuit breakers with a half-open probe, kept in one table.
// ---------------------------------------------------------------------------
// Usage:
//   Commands arrive as beats on the s_* stream: query, failure report or
//   success report for one backend, stamped with the time in seconds. Each
//   accepted beat yields exactly one result beat on the m_* stream
//   (blocked, probe_granted, tripped), in order.
//   Configuration goes through the cfg_* write channel (always ready); the user
//   must see that it is changed only while no command is in flight (unchecked).
//   A beat and its entry are registered in the read stage, its result in the
//   output register. Throughput: one beat per cycle while m_tready keeps up.
//   The table is a single-port write, single-port read memory; the entry is
//   read on acceptance and written back as the command leaves the read stage.
//   A read of an entry being written back gets the new value by forwarding.
//   Reset: the configuration registers take their reset values and the
//   table is swept to zero, one entry per cycle, over all MAX_BACKENDS entries;
//   s_tready stays low during the sweep.
//   Stall: the result waits in the output register; one more command may
//   sit in the read stage, after which s_tready drops until m_tready.
// ---------------------------------------------------------------------------
`include "circuit_breaker_table_top_assert.svh"

module circuit_breaker_table_top #(
	parameter int MAX_BACKENDS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [1:0] cmd, [7:2] backend, [39:8] now_seconds
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] blocked, [1] probe_granted, [2] tripped, [7:3] zero
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import cbt_pkg::*;

	localparam int AW = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
	localparam int XW = (AW > 6) ? AW : 6;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} state_t;

	state_t       state_q;
	logic [AW-1:0] clr_q;

	cbt_cfg_t     cfg;

	// read stage
	logic         valid_s1;
	cbt_cmd_t     cmd_s1;
	logic [5:0]   idx_s1;
	logic [31:0]  now_s1;
	logic         fwd_s1;
	cbt_entry_t   fwd_data_s1;

	// output register
	logic         m_tvalid_q;
	cbt_result_t  res_q;

	logic         s_accept;
	logic         adv_s1;
	logic         in_range;
	logic         upd_we;
	logic         wr_item;
	cbt_entry_t   rdata;
	cbt_entry_t   cur_entry;
	cbt_entry_t   nxt_entry;
	cbt_result_t  res;

	logic [XW-1:0] rd_addr_x;
	logic [XW-1:0] wr_addr_x;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	cbt_entry_t    mem_wdata;

	assign cfg_ready = 1'b1;

	cbt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// handshake
	assign adv_s1   = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_RUN) && (!valid_s1 || adv_s1);
	assign s_accept = s_tvalid && s_tready;

	// index in range of both the configured count and the table depth
	assign in_range = ({1'b0, idx_s1} < cfg.backend_count) &&
	                  (32'(idx_s1) < 32'(MAX_BACKENDS));

	assign cur_entry = fwd_s1 ? fwd_data_s1 : rdata;

	cbt_update u_update (
		.cfg         (cfg),
		.cmd         (cmd_s1),
		.in_range    (in_range),
		.now_seconds (now_s1),
		.cur         (cur_entry),
		.nxt         (nxt_entry),
		.we          (upd_we),
		.res         (res)
	);

	assign wr_item   = valid_s1 && adv_s1 && upd_we;
	assign rd_addr_x = XW'(s_tdata[7:2]);
	assign wr_addr_x = XW'(idx_s1);

	// sweep writes zeros; otherwise the read stage writes back
	assign mem_we    = (state_q == ST_CLEAR) || wr_item;
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : wr_addr_x[AW-1:0];
	assign mem_wdata = (state_q == ST_CLEAR) ? cbt_entry_t'('0) : nxt_entry;

	cbt_mem #(
		.DEPTH (MAX_BACKENDS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (s_accept),
		.raddr (rd_addr_x[AW-1:0]),
		.rdata (rdata)
	);

	// reset sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == AW'(MAX_BACKENDS - 1)) begin
						state_q <= ST_RUN;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				ST_RUN: begin
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv_s1) begin
			valid_s1 <= s_accept;
		end
	end

	// read stage payload; forward when the entry is written as it is read
	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1      <= cbt_cmd_t'(s_tdata[1:0]);
			idx_s1      <= s_tdata[7:2];
			now_s1      <= s_tdata[39:8];
			fwd_s1      <= wr_item && (idx_s1 == s_tdata[7:2]);
			fwd_data_s1 <= nxt_entry;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (valid_s1 && adv_s1) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, res_q};

	// checks
	`CBT_ASSERT_NOW(a_no_accept_in_sweep, state_q == ST_CLEAR, !s_tready)
	`CBT_ASSERT_NOW(a_one_result_flag, m_tvalid, $onehot0(m_tdata[2:0]))
	`CBT_ASSERT_NOW(a_write_only_on_advance, mem_we && (state_q == ST_RUN),
		valid_s1 && adv_s1)
	`CBT_ASSERT_NEXT(a_stage_holds, valid_s1 && !adv_s1,
		valid_s1 && $stable(idx_s1) && $stable(cmd_s1))

endmodule

[bench/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for circuit_breaker_table_top. A queue of pending
// operations (command beats, register writes, drain points) feeds a clocked
// driver; a clocked monitor checks every result beat against an in-bench
// breaker table model that is updated as each command beat is accepted.
// ---------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cbt_pkg::*;

	localparam logic [1:0] CMD_SPARE = 2'd3;   // unused opcode, must be a no-op
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned LONG_HOLD_AT = 1200;      // results seen before the long stall
	localparam int unsigned LONG_HOLD_CYCLES = 300;
	localparam int unsigned FAIL_RUN = 60;            // back-to-back failures on one entry

	typedef enum logic [1:0] {
		OP_BEAT,
		OP_CFG,
		OP_DRAIN
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic        tight;      // no sender gap after this beat
		logic [1:0]  cmd;
		logic [5:0]  backend;
		logic [31:0] now;
		logic [3:0]  reg_idx;
		logic [15:0] reg_val;
	} cbt_op_t;

	// DUT ports, all inputs known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;     // [1:0] cmd, [7:2] backend, [39:8] now_seconds
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;          // [0] blocked, [1] probe_granted, [2] tripped
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// breaker table model, reset values
	logic        brk_en = 1'b0;
	logic [15:0] trip_level = 16'd5;
	logic [15:0] cool_s = 16'd30;
	logic [6:0]  live_count = 7'd0;
	logic [15:0] fail_tally [64] = '{default: '0};
	logic [31:0] open_till [64] = '{default: '0};
	logic        is_open [64] = '{default: 1'b0};
	logic        probe_out [64] = '{default: 1'b0};

	cbt_op_t     cmd_backlog [$];
	cbt_result_t verdicts_due [$];
	int unsigned err_count = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count = 0;

	// driver bookkeeping
	cbt_op_t     drv_head;
	logic        drv_beat;
	logic        drv_reg;
	int unsigned send_gap = 0;
	logic        send_burst = 1'b0;

	// monitor bookkeeping
	cbt_result_t mon_got;
	cbt_result_t mon_want;
	int unsigned recv_wait = 0;
	int unsigned hold_left = 0;
	logic        recv_burst = 1'b0;
	logic        long_hold_done = 1'b0;

	circuit_breaker_table_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// -----------------------------------------------------------------------
	// Model: one command against the breaker table, returns the result beat
	// -----------------------------------------------------------------------
	function automatic cbt_result_t breaker_step(logic [1:0] cmd, logic [5:0] b,
			logic [31:0] now);
		cbt_result_t r;
		logic [32:0] reopen;
		r = '0;
		// out-of-range index: no state change, all-zero result
		if ({1'b0, b} < live_count) begin
			case (cmd)
				CMD_QUERY: begin
					if (brk_en && is_open[b]) begin
						// cooldown over and nobody probing yet: this one is the probe
						if (now >= open_till[b] && !probe_out[b]) begin
							probe_out[b] = 1'b1;
							r.probe_granted = 1'b1;
						end else begin
							r.blocked = 1'b1;
						end
					end
				end
				CMD_FAIL: begin
					probe_out[b] = 1'b0;
					if (fail_tally[b] != CNT_MAX)
						fail_tally[b] = fail_tally[b] + 16'd1;
					if (brk_en && fail_tally[b] >= trip_level) begin
						reopen = {1'b0, now} + {17'd0, cool_s};
						open_till[b] = reopen[32] ? TIME_MAX : reopen[31:0];
						is_open[b] = 1'b1;
						r.tripped = 1'b1;
					end
				end
				CMD_PASS: begin
					fail_tally[b] = '0;
					open_till[b] = '0;
					is_open[b] = 1'b0;
					probe_out[b] = 1'b0;
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	function automatic void apply_reg(logic [3:0] idx, logic [15:0] val);
		case (idx)
			CFG_IDX_ENABLE:    brk_en = val[0];
			CFG_IDX_THRESHOLD: trip_level = val;
			CFG_IDX_COOLDOWN:  cool_s = val;
			CFG_IDX_COUNT:     live_count = val[6:0];
			default: ;
		endcase
	endfunction

	// -----------------------------------------------------------------------
	// Stimulus queue helpers
	// -----------------------------------------------------------------------
	function automatic void push_beat(logic [1:0] c, logic [5:0] b, logic [31:0] t,
			logic tight_run = 1'b0);
		cbt_op_t op;
		op = '0;
		op.kind = OP_BEAT;
		op.tight = tight_run;
		op.cmd = c;
		op.backend = b;
		op.now = t;
		cmd_backlog.push_back(op);
	endfunction

	function automatic void push_cfg(logic [3:0] idx, logic [15:0] val);
		cbt_op_t op;
		op = '0;
		op.kind = OP_CFG;
		op.reg_idx = idx;
		op.reg_val = val;
		cmd_backlog.push_back(op);
	endfunction

	function automatic void push_drain();
		cbt_op_t op;
		op = '0;
		op.kind = OP_DRAIN;
		cmd_backlog.push_back(op);
	endfunction

	function automatic void push_regs(logic en, logic [15:0] th, logic [15:0] cd,
			logic [6:0] cnt);
		push_cfg(CFG_IDX_ENABLE, {15'd0, en});
		push_cfg(CFG_IDX_THRESHOLD, th);
		push_cfg(CFG_IDX_COOLDOWN, cd);
		push_cfg(CFG_IDX_COUNT, {9'd0, cnt});
	endfunction

	// Random traffic: a few hot backends so entries actually trip, probe and
	// recover; time mostly creeps forward on the scale of the cooldown.
	function automatic void random_phase(int unsigned n, logic [6:0] cnt, logic [15:0] cd,
			logic [31:0] t0);
		logic [31:0] t;
		logic [5:0]  hot [4];
		logic [5:0]  b;
		logic [1:0]  c;
		int unsigned pick;
		t = t0;
		for (int k = 0; k < 4; k++)
			hot[k] = (cnt == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, cnt - 1));
		for (int unsigned i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			b = (pick < 75) ? hot[$urandom_range(0, 3)] : 6'($urandom_range(0, 63));
			if ($urandom_range(0, 3) == 0)
				t = t + $urandom_range(0, int'(cd) * 3 / 2 + 2);
			if ($urandom_range(0, 199) == 0)
				t = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 50)
				c = CMD_QUERY;
			else if (pick < 85)
				c = CMD_FAIL;
			else if (pick < 97)
				c = CMD_PASS;
			else
				c = CMD_SPARE;
			push_beat(c, b, t);
			if ($urandom_range(0, 149) == 0)
				push_drain();
		end
	endfunction

	// -----------------------------------------------------------------------
	// Stimulus and end of run
	// -----------------------------------------------------------------------
	initial begin
		logic        en;
		logic [15:0] th;
		logic [15:0] cd;
		logic [6:0]  cnt;
		logic [31:0] t0;

		// reset config: no backends in use, everything reads as out of range
		push_beat(CMD_QUERY, 6'd0, 32'd0);
		push_beat(CMD_FAIL, 6'd5, 32'd0);

		// threshold zero trips on every failure; long cooldown saturates
		push_regs(1'b1, 16'd0, 16'hFFFF, 7'd64);
		push_beat(CMD_FAIL, 6'd63, 32'hFFFF_FFF0);
		push_beat(CMD_QUERY, 6'd63, 32'hFFFF_FFFE);
		push_beat(CMD_QUERY, 6'd63, 32'hFFFF_FFFF);
		push_beat(CMD_QUERY, 6'd63, 32'hFFFF_FFFF);
		push_beat(CMD_SPARE, 6'd63, 32'hFFFF_FFFF);
		push_beat(CMD_FAIL, 6'd0, 32'd0);
		push_beat(CMD_QUERY, 6'd0, 32'd65534);
		push_beat(CMD_QUERY, 6'd0, 32'd65535);
		push_beat(CMD_PASS, 6'd0, 32'd65535);
		push_beat(CMD_QUERY, 6'd0, 32'd65535);

		// zero cooldown, small table: index 10 is past the end
		push_regs(1'b1, 16'd2, 16'd0, 7'd10);
		push_beat(CMD_FAIL, 6'd9, 32'hAAAA_5555);
		push_beat(CMD_FAIL, 6'd9, 32'hAAAA_5555);
		push_beat(CMD_QUERY, 6'd9, 32'hAAAA_5555);
		push_beat(CMD_FAIL, 6'd9, 32'h5555_AAAA);
		push_beat(CMD_QUERY, 6'd9, 32'h5555_AAAA);
		push_beat(CMD_QUERY, 6'd10, 32'h5555_AAAA);
		push_beat(CMD_FAIL, 6'd10, 32'h5555_AAAA);

		// breaker disabled: counts go on, nothing blocks or trips
		push_cfg(CFG_IDX_ENABLE, 16'd0);
		push_beat(CMD_QUERY, 6'd9, 32'h5555_AAAA);
		push_beat(CMD_FAIL, 6'd9, 32'h5555_AAAA);
		push_beat(CMD_PASS, 6'd9, 32'h5555_AAAA);
		push_beat(CMD_SPARE, 6'd42, 32'h0000_0001);

		// long failure run on one entry at the top threshold, back to back
		push_regs(1'b1, 16'hFFFF, 16'd7, 7'd2);
		for (int unsigned i = 0; i < FAIL_RUN; i++)
			push_beat(CMD_FAIL, 6'd1, 32'd100, 1'b1);
		push_beat(CMD_QUERY, 6'd1, 32'd100);
		push_beat(CMD_FAIL, 6'd1, 32'd100);
		push_beat(CMD_FAIL, 6'd1, 32'd101);
		push_beat(CMD_QUERY, 6'd1, 32'd107);
		push_beat(CMD_QUERY, 6'd1, 32'd108);
		push_beat(CMD_FAIL, 6'd1, 32'd108);
		push_beat(CMD_PASS, 6'd1, 32'd200);
		push_beat(CMD_FAIL, 6'd1, 32'd200);

		// random phases, each under its own register setting
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin
					en = 1'b1; th = 16'd0; cd = 16'd0; cnt = 7'd64; t0 = 32'd0;
				end
				1: begin
					en = 1'b1; th = 16'd1; cd = 16'd3; cnt = 7'd1; t0 = $urandom;
				end
				2: begin
					en = 1'b0; th = 16'd2; cd = 16'd10; cnt = 7'd64; t0 = $urandom;
				end
				3: begin
					en = 1'b1; th = 16'd3; cd = 16'hFFFF; cnt = 7'd33; t0 = 32'hFFFF_0000;
				end
				default: begin
					en = ($urandom_range(0, 7) != 0);
					th = 16'($urandom_range(0, 4));
					cd = 16'($urandom_range(0, 40));
					cnt = 7'($urandom_range(0, 64));
					t0 = $urandom;
				end
			endcase
			push_regs(en, th, cd, cnt);
			random_phase(240, cnt, cd, t0);
		end

		// wait for the queue to empty and every result to come back
		do
			@(posedge clk);
		while (cmd_backlog.size() != 0 || s_tvalid || cfg_valid || verdicts_due.size() != 0);
		repeat (4) @(posedge clk);
		if (err_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// -----------------------------------------------------------------------
	// Driver: command beats and register writes from the backlog
	// -----------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			// prediction happens at acceptance so the model sees config in order
			if (s_tvalid && s_tready)
				verdicts_due.push_back(breaker_step(s_tdata[1:0], s_tdata[7:2], s_tdata[39:8]));
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);

			if (!((s_tvalid && !s_tready) || (cfg_valid && !cfg_ready))) begin
				drv_beat = 1'b0;
				drv_reg = 1'b0;
				if (send_gap != 0) begin
					send_gap--;
				end else if (cmd_backlog.size() != 0) begin
					drv_head = cmd_backlog[0];
					case (drv_head.kind)
						OP_BEAT: begin
							drv_beat = 1'b1;
							s_tdata <= {drv_head.now, drv_head.backend, drv_head.cmd};
							void'(cmd_backlog.pop_front());
							send_gap = (drv_head.tight || send_burst) ? 0 : $urandom_range(0, 5);
							if ($urandom_range(0, 63) == 0)
								send_burst = !send_burst;
						end
						// register writes only with nothing in flight
						OP_CFG: begin
							if (verdicts_due.size() == 0) begin
								drv_reg = 1'b1;
								cfg_index <= drv_head.reg_idx;
								cfg_data <= drv_head.reg_val;
								void'(cmd_backlog.pop_front());
							end
						end
						OP_DRAIN: begin
							if (verdicts_due.size() == 0)
								void'(cmd_backlog.pop_front());
						end
						default: ;
					endcase
				end
				s_tvalid <= drv_beat;
				cfg_valid <= drv_reg;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Monitor: result beats against the oldest expectation
	// -----------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				mon_got = cbt_result_t'(m_tdata[2:0]);
				if (verdicts_due.size() == 0) begin
					$error("result beat %0h with nothing expected", m_tdata);
					err_count++;
				end else begin
					mon_want = verdicts_due.pop_front();
					if (mon_got.blocked !== mon_want.blocked) begin
						$error("blocked: expected %0d, got %0d", mon_want.blocked,
							mon_got.blocked);
						err_count++;
					end
					if (mon_got.probe_granted !== mon_want.probe_granted) begin
						$error("probe_granted: expected %0d, got %0d",
							mon_want.probe_granted, mon_got.probe_granted);
						err_count++;
					end
					if (mon_got.tripped !== mon_want.tripped) begin
						$error("tripped: expected %0d, got %0d", mon_want.tripped,
							mon_got.tripped);
						err_count++;
					end
				end
				results_seen++;
				recv_wait = recv_burst ? 0 : $urandom_range(0, 5);
				if ($urandom_range(0, 63) == 0)
					recv_burst = !recv_burst;
			end

			// one long back-pressure stretch, started while the sender is offering
			if (results_seen >= LONG_HOLD_AT && !long_hold_done && s_tvalid) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES;
			end

			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (recv_wait != 0) begin
				recv_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

endmodule
